/* src/rmst_pkg.sv */
// ----------------------------------------------------------------------------
// rmst_pkg
// Shared constants and controller/datapath handshake types for the
// range-minimum segment tree.
// ----------------------------------------------------------------------------
package rmst_pkg;

   localparam int INDEX_BITS = 10;
   localparam int VALUE_PORT_BITS = 32;
   localparam int CSR_BITS = 11;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // commands from the controller to the datapath
   typedef struct packed {
      logic clear_wr;   // write the largest value at the sweep address
      logic load;       // capture a request
      logic leaf_wr;    // write the leaf and fetch its sibling
      logic up_wr;      // repair one parent and fetch the next sibling
      logic q_lo;       // fetch the node at the low bound
      logic q_hi;       // fetch the node below the high bound, climb a level
      logic resp_err;   // present an index error
      logic resp_empty; // present an empty range
      logic resp_min;   // present the accumulated minimum
   } rmst_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic clear_last;
      logic index_err;
      logic range_empty;
      logic is_query;
      logic up_root;
      logic lo_lt_hi;
   } rmst_status_type;

endpackage

/* src/rmst_ram.sv */
// ----------------------------------------------------------------------------
// rmst_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module rmst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

/* src/rmst_ctrl.sv */
// ----------------------------------------------------------------------------
// rmst_ctrl
// Sequencer for the segment tree: clearing sweep, leaf-to-root repair for
// writes and the two-bound climb for queries.
// ----------------------------------------------------------------------------
module rmst_ctrl
   import rmst_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  rmst_status_type status,
   output rmst_cmd_type    cmd
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_WUP   = 3'd3;
   localparam logic [2:0] S_QLO   = 3'd4;
   localparam logic [2:0] S_QHI   = 3'd5;
   localparam logic [2:0] S_QEND  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.index_err) begin
               cmd.resp_err = 1'b1;
               state_in     = S_IDLE;
            end else if (!status.is_query) begin
               cmd.leaf_wr = 1'b1;
               state_in    = S_WUP;
            end else if (status.range_empty) begin
               cmd.resp_empty = 1'b1;
               state_in       = S_IDLE;
            end else begin
               state_in = S_QLO;
            end
         end
         S_WUP: begin
            cmd.up_wr = 1'b1;
            if (status.up_root) begin
               state_in = S_IDLE;
            end
         end
         S_QLO: begin
            if (status.lo_lt_hi) begin
               cmd.q_lo = 1'b1;
               state_in = S_QHI;
            end else begin
               state_in = S_QEND;
            end
         end
         S_QHI: begin
            cmd.q_hi = 1'b1;
            state_in = S_QLO;
         end
         S_QEND: begin
            cmd.resp_min = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

/* src/rmst_datapath.sv */
// ----------------------------------------------------------------------------
// rmst_datapath
// Node memory, request registers, bound and path registers, the running
// minimum and the result register.
// ----------------------------------------------------------------------------
module rmst_datapath
   import rmst_pkg::*;
#(
   parameter int MAX_ELEMENTS = 1024,
   parameter int VALUE_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_opcode,
   input  logic [INDEX_BITS-1:0]             req_first_index,
   input  logic [INDEX_BITS-1:0]             req_last_index,
   input  logic signed [VALUE_PORT_BITS-1:0] req_value,
   input  logic                              csr_we,
   input  logic [CSR_BITS-1:0]               csr_wdata,
   input  rmst_cmd_type                      cmd,
   output rmst_status_type                   status,
   output logic                              rsp_valid,
   output logic signed [VALUE_PORT_BITS-1:0] rsp_minimum,
   output logic                              rsp_range_empty,
   output logic                              rsp_index_error
);

   localparam int W     = (VALUE_BITS > VALUE_PORT_BITS) ? VALUE_PORT_BITS : VALUE_BITS;
   localparam int DEPTH = 2 * MAX_ELEMENTS;
   localparam int AW    = $clog2(DEPTH);
   localparam int NW    = $clog2(DEPTH + 1);
   localparam int CNTW  = $clog2(MAX_ELEMENTS + 1);
   localparam int CW    = (CNTW > CSR_BITS) ? CNTW : CSR_BITS;
   localparam logic signed [W-1:0] LARGEST = {1'b0, {(W-1){1'b1}}};

   logic                   op_ff, op_in;
   logic [INDEX_BITS-1:0]  first_ff, first_in;
   logic [INDEX_BITS-1:0]  last_ff, last_in;
   logic signed [W-1:0]    cur_ff, cur_in;
   logic [AW-1:0]          k_ff, k_in;
   logic [NW-1:0]          lo_ff, lo_in;
   logic [NW-1:0]          hi_ff, hi_in;
   logic signed [W-1:0]    best_ff, best_in;
   logic                   acc_ff, acc_in;
   logic [AW-1:0]          clr_addr_ff, clr_addr_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [W-1:0]    rsp_min_ff, rsp_min_in;
   logic                   rsp_empty_ff, rsp_empty_in;
   logic                   rsp_err_ff, rsp_err_in;

   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [W-1:0]           wr_data;
   logic [AW-1:0]          rd_addr;
   logic [W-1:0]           rd_data;
   logic signed [W-1:0]    node_val;
   logic [CW-1:0]          active;
   logic [AW-1:0]          leaf_addr;
   logic [AW-1:0]          parent;
   logic [NW-1:0]          hi_dec;
   logic signed [W-1:0]    up_min;

   rmst_ram #(
      .WIDTH (W),
      .DEPTH (DEPTH)
   ) u_nodes (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign node_val  = $signed(rd_data);
   assign active    = (count_ff > CW'(MAX_ELEMENTS)) ? CW'(MAX_ELEMENTS) : count_ff;
   assign leaf_addr = AW'(MAX_ELEMENTS) + AW'(first_ff);
   assign parent    = k_ff >> 1;
   assign hi_dec    = hi_ff - NW'(1);
   assign up_min    = (node_val < cur_ff) ? node_val : cur_ff;

   // status back to the sequencer
   always_comb begin
      status.clear_last  = (clr_addr_ff == AW'(DEPTH - 1));
      status.index_err   = (CW'(first_ff) >= active) ||
                           ((op_ff == OP_QUERY) && (CW'(last_ff) >= active));
      status.range_empty = (first_ff > last_ff);
      status.is_query    = (op_ff == OP_QUERY);
      status.up_root     = (parent == AW'(1));
      status.lo_lt_hi    = (lo_ff < hi_ff);
   end

   // memory port steering
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_addr_ff;
      wr_data = LARGEST;
      rd_addr = '0;
      if (cmd.clear_wr) begin
         wr_en = 1'b1;
      end
      if (cmd.leaf_wr) begin
         wr_en   = 1'b1;
         wr_addr = leaf_addr;
         wr_data = cur_ff;
         rd_addr = leaf_addr ^ AW'(1);
      end
      if (cmd.up_wr) begin
         wr_en   = 1'b1;
         wr_addr = parent;
         wr_data = up_min;
         rd_addr = parent ^ AW'(1);
      end
      if (cmd.q_lo) begin
         rd_addr = lo_ff[AW-1:0];
      end
      if (cmd.q_hi) begin
         rd_addr = hi_dec[AW-1:0];
      end
   end

   // next-state values
   always_comb begin
      op_in        = op_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      cur_in       = cur_ff;
      k_in         = k_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      best_in      = best_ff;
      acc_in       = (cmd.q_lo & lo_ff[0]) | (cmd.q_hi & hi_ff[0]);
      clr_addr_in  = cmd.clear_wr ? (clr_addr_ff + AW'(1)) : clr_addr_ff;
      count_in     = csr_we ? CW'(csr_wdata) : count_ff;
      rsp_valid_in = cmd.resp_err | cmd.resp_empty | cmd.resp_min;
      rsp_min_in   = rsp_min_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_err_in   = rsp_err_ff;

      if (acc_ff && (node_val < best_ff)) begin
         best_in = node_val;
      end
      if (cmd.load) begin
         op_in    = req_opcode;
         first_in = req_first_index;
         last_in  = req_last_index;
         cur_in   = W'(req_value);
         lo_in    = NW'(MAX_ELEMENTS) + NW'(req_first_index);
         hi_in    = NW'(MAX_ELEMENTS) + NW'(req_last_index) + NW'(1);
         best_in  = LARGEST;
      end
      if (cmd.leaf_wr) begin
         k_in = leaf_addr;
      end
      if (cmd.up_wr) begin
         k_in   = parent;
         cur_in = up_min;
      end
      if (cmd.q_hi) begin
         lo_in = (lo_ff + NW'(lo_ff[0])) >> 1;
         hi_in = hi_ff >> 1;
      end
      if (cmd.resp_err) begin
         rsp_min_in   = '0;
         rsp_empty_in = 1'b0;
         rsp_err_in   = 1'b1;
      end
      if (cmd.resp_empty) begin
         rsp_min_in   = LARGEST;
         rsp_empty_in = 1'b1;
         rsp_err_in   = 1'b0;
      end
      if (cmd.resp_min) begin
         rsp_min_in   = best_ff;
         rsp_empty_in = 1'b0;
         rsp_err_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= 1'b0;
         clr_addr_ff  <= '0;
         count_ff     <= CW'(MAX_ELEMENTS);
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         clr_addr_ff  <= clr_addr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      first_ff     <= first_in;
      last_ff      <= last_in;
      cur_ff       <= cur_in;
      k_ff         <= k_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      best_ff      <= best_in;
      rsp_min_ff   <= rsp_min_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_minimum     = VALUE_PORT_BITS'(rsp_min_ff);
   assign rsp_range_empty = rsp_empty_ff;
   assign rsp_index_error = rsp_err_ff;

endmodule

/* src/range_min_segment_tree_unit.sv */
// ----------------------------------------------------------------------------
// range_min_segment_tree_unit
// Segment tree of signed minimums with single-element writes and inclusive
// range-minimum queries.
// ----------------------------------------------------------------------------
// Usage
//   Request channel: drive req_* and raise start; the request is taken at a
//   clock edge where start is high and busy is low. Opcode write sets one
//   element, opcode query asks for the minimum over first..last inclusive.
//   Result channel: rsp_valid is high for exactly one cycle with rsp_minimum,
//   rsp_range_empty and rsp_index_error. The receiver cannot stall, so take
//   the result in that cycle. A valid write gives no result; a write or a
//   query that names an index at or beyond the element count gives one
//   result with rsp_index_error set and rsp_minimum zero.
//   CSR: pulse csr_we with csr_wdata to set the element count; only while
//   the block is idle. Counts above MAX_ELEMENTS act as MAX_ELEMENTS.
// Sequence
//   A write stores the leaf, then repairs one parent per tree level up to
//   the root; each level costs one node memory access on the single read port.
//   A query climbs both bounds with two accesses per level, one for each
//   bound. Errors and empty ranges are answered from the check state.
// Reset
//   Reset starts a clearing sweep that writes the largest value into all
//   2*MAX_ELEMENTS nodes, one a cycle; busy stays high until the sweep ends.
// ----------------------------------------------------------------------------
module range_min_segment_tree_unit
   import rmst_pkg::*;
#(
   parameter int MAX_ELEMENTS = 1024,
   parameter int VALUE_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_opcode,
   input  logic [INDEX_BITS-1:0]             req_first_index,
   input  logic [INDEX_BITS-1:0]             req_last_index,
   input  logic signed [VALUE_PORT_BITS-1:0] req_value,
   input  logic                              csr_we,
   input  logic [CSR_BITS-1:0]               csr_wdata,
   output logic                              rsp_valid,
   output logic signed [VALUE_PORT_BITS-1:0] rsp_minimum,
   output logic                              rsp_range_empty,
   output logic                              rsp_index_error
);

   rmst_cmd_type    cmd;
   rmst_status_type status;

   // sequencer: owns the clearing sweep and the per-level stepping
   rmst_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // node memory, bound registers, running minimum and result register
   rmst_datapath #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .VALUE_BITS   (VALUE_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_opcode      (req_opcode),
      .req_first_index (req_first_index),
      .req_last_index  (req_last_index),
      .req_value       (req_value),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_minimum     (rsp_minimum),
      .rsp_range_empty (rsp_range_empty),
      .rsp_index_error (rsp_index_error)
   );

   // a result appears only as the sequencer drops back to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // results are single-cycle strobes, never back to back
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // an index error and an empty range never come together
   a_rsp_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_range_empty && rsp_index_error))
      else $error("conflicting result flags");

   // an accepted request always occupies the block next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted without going busy");

   // a request load and the tree-walking steps are never issued together
   a_no_cmd_mix: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.load, cmd.leaf_wr, cmd.up_wr, cmd.q_lo, cmd.q_hi}) <= 1)
      else $error("overlapping sequencer commands");

endmodule
